### sv/assert_macros.svh
// Assertion macros shared by the dither core.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define EDD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/edd_pkg.sv
// Package for the RGBA error diffusion dither: widths, payload structs,
// register indexes and the depth-to-mask helper. No dependencies.
package edd_pkg;

	localparam int NCH       = 4;   // red, green, blue, alpha
	localparam int PIX_W     = 8;
	localparam int WIDE_W    = 12;  // channel scaled by 16
	localparam int SUM_W     = 14;  // pixel plus both error terms
	localparam int ERR_W     = 12;  // signed rounding error and stored error
	localparam int DEPTH_W   = 4;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 3;
	localparam int Q_DEPTH   = 3;   // farthest tap below-left

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd1024;
	localparam logic [DEPTH_W-1:0] DEPTH_RST = 4'd8;
	localparam logic [DEPTH_W-1:0] DEPTH_MIN = 4'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_RED_DEPTH    = 3'd2,
		CFG_GREEN_DEPTH  = 3'd3,
		CFG_BLUE_DEPTH   = 3'd4,
		CFG_ALPHA_DEPTH  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
		logic [PIX_W-1:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic [PIX_W-1:0] alpha_out;
		logic             frame_done;
	} pix_out_t;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef err_t [NCH-1:0] err_vec_t;

	// Per-channel quantizer results.
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		err_t             e_half;
		err_t             e_quarter;
		err_t             e_eighth;
	} quant_res_t;

	// Mask of the dropped low bits of the 12-bit value for a kept depth.
	function automatic logic [WIDE_W-1:0] depth_mask(input logic [DEPTH_W-1:0] dep);
		logic [DEPTH_W-1:0] d;
		logic [WIDE_W:0]    one_hot;
		if (dep < DEPTH_MIN) begin
			d = DEPTH_MIN;
		end else if (dep > DEPTH_MAX) begin
			d = DEPTH_MAX;
		end else begin
			d = dep;
		end
		one_hot = (WIDE_W+1)'(1) << (DEPTH_W'(WIDE_W) - d);
		return WIDE_W'(one_hot - (WIDE_W+1)'(1));
	endfunction

endpackage

### sv/error_diffusion_dither_rgba_core.sv
// RGBA error diffusion dither core; uses edd_pkg, edd_quant, assert_macros.svh.
// Each accepted item is registered in stage s1, then in the output register.
// Throughput: one item per cycle unless out_ready stalls it; no carry bubble.
// Reset: arst_n clears control, counters, carries and restores register defaults.
// The line memory is never swept: a per-frame fill count masks unwritten columns.
`include "assert_macros.svh"

module error_diffusion_dither_rgba_core import edd_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pix_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pix_out_t             out_data
);

	// column address, width compare and fill count widths
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int WCMP = (WW > SIZE_W) ? WW : SIZE_W;
	localparam int HCMP = (HW > SIZE_W) ? HW : SIZE_W;

	// ------------------------------------------------------------------
	// Configuration registers; the port never stalls.
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0]  image_width_q;
	logic [SIZE_W-1:0]  image_height_q;
	logic [DEPTH_W-1:0] depth_q [NCH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_RST;
			image_height_q <= SIZE_RST;
			for (int c = 0; c < NCH; c++) begin
				depth_q[c] <= DEPTH_RST;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_RED_DEPTH:    depth_q[0]     <= cfg_data[DEPTH_W-1:0];
				CFG_GREEN_DEPTH:  depth_q[1]     <= cfg_data[DEPTH_W-1:0];
				CFG_BLUE_DEPTH:   depth_q[2]     <= cfg_data[DEPTH_W-1:0];
				CFG_ALPHA_DEPTH:  depth_q[3]     <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, saturate at the maxima.
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WW'(1);
		end else if (WCMP'(image_width_q) > WCMP'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_eff = HW'(1);
		end else if (HCMP'(image_height_q) > HCMP'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(image_height_q);
		end
	end

	// ------------------------------------------------------------------
	// Handshake. Stage s1 does the read-modify-write and only moves when
	// the output register is free or being drained, so each item updates
	// the error state exactly once.
	// ------------------------------------------------------------------
	logic s1_valid_q;
	logic s1_adv;
	logic in_acc;
	logic out_valid_q;

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_acc   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Raster position of the next item; advance on accept.
	// ------------------------------------------------------------------
	logic [CW-1:0] cc_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] x_a;
	logic          last_col_a;
	logic          last_row_a;
	logic          fstart_a;

	always_comb begin
		last_col_a = (WW'(cc_q) + WW'(1)) >= w_eff;
		last_row_a = (HW'(row_q) + HW'(1)) >= h_eff;
		// a column past a shrunk width lands on the last column
		x_a        = (WW'(cc_q) < w_eff) ? cc_q : CW'(w_eff - WW'(1));
		fstart_a   = (cc_q == '0) && (row_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q  <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col_a) begin
				cc_q  <= '0;
				row_q <= last_row_a ? '0 : row_q + RW'(1);
			end else begin
				cc_q <= cc_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage s1 registers and the line memory read.
	// ------------------------------------------------------------------
	logic [NCH-1:0][PIX_W-1:0] pix_s1;
	logic [CW-1:0]             x_s1;
	logic                      last_col_s1;
	logic                      last_row_s1;
	logic                      fstart_s1;
	err_vec_t                  mem_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1[0]   <= in_data.red_in;
			pix_s1[1]   <= in_data.green_in;
			pix_s1[2]   <= in_data.blue_in;
			pix_s1[3]   <= in_data.alpha_in;
			x_s1        <= x_a;
			last_col_s1 <= last_col_a;
			last_row_s1 <= last_row_a;
			fstart_s1   <= fstart_a;
		end
	end

	// Error gathered for the next row, one word per column, four channels.
	err_vec_t line_mem [MAX_WIDTH];
	logic     mem_we;
	err_vec_t upd2;

	// Write-back queue: the last three columns pushed, newest in slot 0.
	// An entry stays here while later pixels of its row may still add e/8;
	// it leaves for memory three items later.
	logic [Q_DEPTH-1:0] q_vld_q;
	logic [CW-1:0]      q_addr_q [Q_DEPTH];
	err_vec_t           q_err_q  [Q_DEPTH];

	// Most recent memory write, covers a read issued in the same cycle.
	logic          lw_vld_q;
	logic [CW-1:0] lw_addr_q;
	err_vec_t      lw_err_q;

	// Columns written since frame start.
	logic [WW-1:0] fc_q;
	err_vec_t      rc_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[q_addr_q[Q_DEPTH-1]] <= upd2;
		end
		if (in_acc) begin
			mem_rd_s1 <= line_mem[x_a];
		end
	end

	// ------------------------------------------------------------------
	// Stage s1: forward, quantize, diffuse.
	// ------------------------------------------------------------------
	logic [Q_DEPTH-1:0] vld_base;
	logic [WW-1:0]      fc_eff;
	err_vec_t           fwd;
	err_vec_t           above;
	err_vec_t           carry;
	logic               diffuse_s1;
	quant_res_t         res [NCH];

	always_comb begin
		// frame start drops everything gathered for the old frame
		vld_base = fstart_s1 ? '0 : q_vld_q;
		fc_eff   = fstart_s1 ? '0 : fc_q;
		carry    = fstart_s1 ? '0 : rc_q;

		// newest copy wins: queue slot 0, 1, 2, last write, memory
		fwd = mem_rd_s1;
		if (lw_vld_q && (lw_addr_q == x_s1)) begin
			fwd = lw_err_q;
		end
		for (int i = Q_DEPTH - 1; i >= 0; i--) begin
			if (vld_base[i] && (q_addr_q[i] == x_s1)) begin
				fwd = q_err_q[i];
			end
		end
		above      = (WW'(x_s1) < fc_eff) ? fwd : '0;
		diffuse_s1 = !last_col_s1 && !last_row_s1;
	end

	for (genvar c = 0; c < NCH; c++) begin : g_chan
		edd_quant u_quant (
			.pix   (pix_s1[c]),
			.carry (carry[c]),
			.above (above[c]),
			.mask  (depth_mask(depth_q[c])),
			.res   (res[c])
		);
	end

	err_vec_t new0;
	err_vec_t upd0;
	err_vec_t rc_next;

	always_comb begin
		upd0 = q_err_q[0];
		upd2 = q_err_q[Q_DEPTH-1];
		for (int c = 0; c < NCH; c++) begin
			new0[c]    = diffuse_s1 ? res[c].e_quarter : '0;
			rc_next[c] = diffuse_s1 ? res[c].e_half : '0;
			// below-left and three-left below take e/8 each
			if (diffuse_s1 && (x_s1 >= CW'(1))) begin
				upd0[c] = q_err_q[0][c] + res[c].e_eighth;
			end
			if (diffuse_s1 && (x_s1 >= CW'(3))) begin
				upd2[c] = q_err_q[Q_DEPTH-1][c] + res[c].e_eighth;
			end
		end
		mem_we = s1_adv && vld_base[Q_DEPTH-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld_q  <= '0;
			lw_vld_q <= 1'b0;
			fc_q     <= '0;
			rc_q     <= '0;
		end else if (s1_adv) begin
			q_vld_q <= {vld_base[Q_DEPTH-2:0], 1'b1};
			if (mem_we) begin
				lw_vld_q <= 1'b1;
			end
			fc_q <= (WW'(x_s1) == fc_eff) ? fc_eff + WW'(1) : fc_eff;
			rc_q <= rc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			q_addr_q[0] <= x_s1;
			q_err_q[0]  <= new0;
			q_addr_q[1] <= q_addr_q[0];
			q_err_q[1]  <= upd0;
			q_addr_q[2] <= q_addr_q[1];
			q_err_q[2]  <= q_err_q[1];
		end
		if (mem_we) begin
			lw_addr_q <= q_addr_q[Q_DEPTH-1];
			lw_err_q  <= upd2;
		end
	end

	// ------------------------------------------------------------------
	// Output register; hold the result until it is taken.
	// ------------------------------------------------------------------
	pix_out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q.red_out    <= res[0].pix;
			out_data_q.green_out  <= res[1].pix;
			out_data_q.blue_out   <= res[2].pix;
			out_data_q.alpha_out  <= res[3].pix;
			out_data_q.frame_done <= last_col_s1 && last_row_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// the last item of a frame wraps the raster position to the origin
	`EDD_ASSERT_NEXT(a_frame_wrap, in_acc && last_col_a && last_row_a, (cc_q == '0) && (row_q == '0) && s1_valid_q, "raster position did not wrap after the last item of a frame")
	// columns are written in order, so the current column never skips past the fill count
	`EDD_ASSERT_NOW(a_col_in_fill, s1_valid_q && !fstart_s1, WW'(x_s1) <= fc_q, "column beyond the fill count of the line memory")
	// a diffusing pixel finds its left neighbor in queue slot 0
	`EDD_ASSERT_NOW(a_queue_align, s1_valid_q && diffuse_s1 && !fstart_s1 && (x_s1 >= CW'(1)), q_vld_q[0] && (q_addr_q[0] == x_s1 - CW'(1)), "write-back queue out of step with the column")

endmodule

### sv/edd_quant.sv
// One channel of the dither: sum, round to depth, split the error.
// Depends on edd_pkg.
module edd_quant import edd_pkg::*; (
	input  logic [PIX_W-1:0]  pix,
	input  err_t              carry,
	input  err_t              above,
	input  logic [WIDE_W-1:0] mask,
	output quant_res_t        res
);

	logic signed [SUM_W-1:0] v;
	logic signed [SUM_W-1:0] t;
	logic signed [SUM_W-1:0] keep;
	logic signed [SUM_W-1:0] q;
	logic signed [SUM_W-1:0] diff;
	err_t                    e;
	logic [PIX_W-1:0]        clip;

	always_comb begin
		v    = $signed({{(SUM_W-WIDE_W){1'b0}}, pix, 4'b0000})
			+ SUM_W'(carry) + SUM_W'(above);
		// round half down, floor on two's complement
		t    = v + $signed({{(SUM_W-WIDE_W+1){1'b0}}, mask[WIDE_W-1:1]});
		keep = $signed({{(SUM_W-WIDE_W){1'b1}}, ~mask});
		q    = t & keep;
		diff = v - q;
		e    = ERR_W'(diff);

		// divisions truncate toward zero: bias negatives before the shift
		res.e_half    = (e + $signed({{(ERR_W-1){1'b0}}, e[ERR_W-1]})) >>> 1;
		res.e_quarter = (e + $signed({{(ERR_W-2){1'b0}}, {2{e[ERR_W-1]}}})) >>> 2;
		res.e_eighth  = (e + $signed({{(ERR_W-3){1'b0}}, {3{e[ERR_W-1]}}})) >>> 3;

		if (q[SUM_W-1]) begin
			clip = '0;
		end else if (|q[SUM_W-2:WIDE_W]) begin
			clip = '1;
		end else begin
			clip = q[WIDE_W-1:WIDE_W-PIX_W];
		end
		res.pix = clip & ~mask[WIDE_W-1:WIDE_W-PIX_W];
	end

endmodule
